FILE: hw/rtl/uerx_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerx_pkg
// shared types and constants of the usb ethernet receive deframer
// ----------------------------------------------------------------------------
package uerx_pkg;

   localparam int unsigned XferLenWidth  = 15;
   localparam int unsigned FrameLenWidth = 11;
   localparam int unsigned KindWidth     = 3;

   localparam logic [XferLenWidth-1:0] MaxTransferBytes = 15'd16384;
   localparam logic [FrameLenWidth-1:0] LenMask = 11'h7ff;

   localparam logic [KindWidth-1:0] KindData      = 3'd0;
   localparam logic [KindWidth-1:0] KindEmpty     = 3'd1;
   localparam logic [KindWidth-1:0] KindMalformed = 3'd2;
   localparam logic [KindWidth-1:0] KindTooLarge  = 3'd3;
   localparam logic [KindWidth-1:0] KindTruncated = 3'd4;

   typedef struct packed {
      logic [7:0]              rx_byte;
      logic                    first_of_transfer;
      logic [XferLenWidth-1:0] transfer_length;
   } req_beat_type;

   typedef struct packed {
      logic [KindWidth-1:0]     kind;
      logic [7:0]               payload_byte;
      logic                     frame_last;
      logic [FrameLenWidth-1:0] frame_length;
   } rsp_beat_type;

endpackage

FILE: hw/rtl/uerx_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerx_req_if
// input byte channel of the receive deframer
// ----------------------------------------------------------------------------
interface uerx_req_if
   import uerx_pkg::*;
;
   logic                    valid;
   logic                    ready;
   logic [7:0]              rx_byte;
   logic                    first_of_transfer;
   logic [XferLenWidth-1:0] transfer_length;

   modport source (output valid, output rx_byte, output first_of_transfer,
                   output transfer_length, input ready);
   modport sink (input valid, input rx_byte, input first_of_transfer,
                 input transfer_length, output ready);
endinterface

FILE: hw/rtl/uerx_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerx_rsp_if
// result channel of the receive deframer
// ----------------------------------------------------------------------------
interface uerx_rsp_if
   import uerx_pkg::*;
;
   logic                     valid;
   logic                     ready;
   logic [KindWidth-1:0]     kind;
   logic [7:0]               payload_byte;
   logic                     frame_last;
   logic [FrameLenWidth-1:0] frame_length;

   modport source (output valid, output kind, output payload_byte,
                   output frame_last, output frame_length, input ready);
   modport sink (input valid, input kind, input payload_byte,
                 input frame_last, input frame_length, output ready);
endinterface

FILE: hw/rtl/uerx_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerx_in_stage
// input register: holds one byte beat until the parser consumes it
// ----------------------------------------------------------------------------
module uerx_in_stage
   import uerx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_beat_type req_beat,
   input  logic         advance,
   output logic         beat_valid,
   output req_beat_type beat
);

   logic         valid_ff;
   logic         valid_in;
   req_beat_type beat_ff;

   assign req_ready  = !valid_ff || advance;
   assign beat_valid = valid_ff;
   assign beat       = beat_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_ready) begin
         valid_in = req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         beat_ff <= req_beat;
      end
   end

endmodule

FILE: hw/rtl/uerx_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerx_parse
// deframing state and the per-byte decision: header gather, length check,
// payload pass-through, pad skip and discard after an error
// ----------------------------------------------------------------------------
module uerx_parse
   import uerx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         advance,
   input  req_beat_type beat,
   output logic         emit,
   output rsp_beat_type result
);

   localparam logic [1:0] PhHeader  = 2'd0;
   localparam logic [1:0] PhPayload = 2'd1;
   localparam logic [1:0] PhPad     = 2'd2;
   localparam logic [1:0] PhDiscard = 2'd3;

   logic [1:0]               phase_ff, phase_in, phase_eff;
   logic [1:0]               hcnt_ff, hcnt_in, hcnt_eff;
   logic [23:0]              hdr_ff, hdr_in;
   logic [FrameLenWidth-1:0] len_ff, len_in;
   logic [FrameLenWidth-1:0] prem_ff, prem_in, prem_eff;
   logic [XferLenWidth-1:0]  xrem_ff, xrem_in, xrem_eff;
   logic                     pad_ff, pad_in, pad_eff;
   logic [XferLenWidth-1:0]  tlen_clamped;
   logic [XferLenWidth-1:0]  left;
   logic [FrameLenWidth-1:0] hdr_len;
   logic [FrameLenWidth-1:0] hdr_chk;
   logic [FrameLenWidth-1:0] prem_dec;

   assign tlen_clamped = (beat.transfer_length > MaxTransferBytes) ?
                         MaxTransferBytes : beat.transfer_length;

   // a first beat restarts the transfer before the byte is looked at
   always_comb begin
      phase_eff = phase_ff;
      hcnt_eff  = hcnt_ff;
      prem_eff  = prem_ff;
      xrem_eff  = xrem_ff;
      pad_eff   = pad_ff;
      if (beat.first_of_transfer) begin
         phase_eff = PhHeader;
         hcnt_eff  = 2'd0;
         prem_eff  = '0;
         xrem_eff  = tlen_clamped;
         pad_eff   = 1'b0;
      end
   end

   assign left     = xrem_eff - 1'b1;
   assign hdr_len  = hdr_ff[FrameLenWidth-1:0];
   assign hdr_chk  = ~{beat.rx_byte[2:0], hdr_ff[23:16]} & LenMask;
   assign prem_dec = (prem_eff != '0) ? prem_eff - 1'b1 : prem_eff;

   always_comb begin
      phase_in = phase_eff;
      hcnt_in  = hcnt_eff;
      hdr_in   = hdr_ff;
      len_in   = len_ff;
      prem_in  = prem_eff;
      xrem_in  = xrem_eff;
      pad_in   = pad_eff;
      emit     = 1'b0;
      result   = '0;
      if (xrem_eff != '0) begin
         xrem_in = left;
         case (phase_eff)
            PhHeader: begin
               case (hcnt_eff)
                  2'd0: begin
                     if (left < 15'd3) begin
                        phase_in    = PhDiscard;
                        emit        = 1'b1;
                        result.kind = KindTruncated;
                     end else begin
                        hdr_in  = {16'h0000, beat.rx_byte};
                        hcnt_in = 2'd1;
                     end
                  end
                  2'd1: begin
                     hdr_in[15:8] = beat.rx_byte;
                     hcnt_in      = 2'd2;
                  end
                  2'd2: begin
                     hdr_in[23:16] = beat.rx_byte;
                     hcnt_in       = 2'd3;
                  end
                  default: begin
                     // fourth header byte completes the length check
                     hcnt_in = 2'd0;
                     emit    = 1'b1;
                     if (hdr_chk != hdr_len) begin
                        phase_in            = PhDiscard;
                        result.kind         = KindMalformed;
                        result.frame_length = hdr_len;
                     end else if ({4'd0, hdr_len} > left) begin
                        phase_in            = PhDiscard;
                        result.kind         = KindTooLarge;
                        result.frame_length = hdr_len;
                     end else if (hdr_len == '0) begin
                        result.kind = KindEmpty;
                     end else begin
                        emit     = 1'b0;
                        len_in   = hdr_len;
                        prem_in  = hdr_len;
                        pad_in   = hdr_len[0];
                        phase_in = PhPayload;
                     end
                  end
               endcase
            end
            PhPayload: begin
               emit                = 1'b1;
               result.kind         = KindData;
               result.payload_byte = beat.rx_byte;
               result.frame_last   = (prem_eff <= 11'd1);
               result.frame_length = len_ff;
               prem_in             = prem_dec;
               if (prem_dec == '0) begin
                  phase_in = pad_eff ? PhPad : PhHeader;
               end
            end
            PhPad: begin
               pad_in   = 1'b0;
               phase_in = PhHeader;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PhHeader;
         hcnt_ff  <= 2'd0;
         hdr_ff   <= '0;
         len_ff   <= '0;
         prem_ff  <= '0;
         xrem_ff  <= '0;
         pad_ff   <= 1'b0;
      end else if (advance) begin
         phase_ff <= phase_in;
         hcnt_ff  <= hcnt_in;
         hdr_ff   <= hdr_in;
         len_ff   <= len_in;
         prem_ff  <= prem_in;
         xrem_ff  <= xrem_in;
         pad_ff   <= pad_in;
      end
   end

endmodule

FILE: hw/rtl/uerx_out_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerx_out_stage
// result register: holds one result beat until the receiver takes it
// ----------------------------------------------------------------------------
module uerx_out_stage
   import uerx_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_beat_type load_beat,
   output logic         space,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_beat_type rsp_beat
);

   logic         valid_ff;
   logic         valid_in;
   rsp_beat_type beat_ff;

   assign space     = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_beat  = beat_ff;

   always_comb begin
      valid_in = valid_ff;
      if (space) begin
         valid_in = load;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (space && load) begin
         beat_ff <= load_beat;
      end
   end

endmodule

FILE: hw/rtl/usb_ethernet_rx_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// usb_ethernet_rx_deframer
// splits usb bulk-in transfers into ethernet frames
// ----------------------------------------------------------------------------
// req_ch carries one transfer byte per beat; the first beat of a transfer has
// first_of_transfer set and the transfer length. rsp_ch carries at most one
// result beat per input beat: a payload byte (frame_last on the final one),
// an empty-frame marker, or one of three error kinds, after which the rest of
// the transfer is dropped. Pad, discarded and out-of-transfer bytes give no
// beat, nor do header bytes unless they report an empty frame or an error.
// Throughput is one byte per cycle unless rsp ready stalls it. An accepted
// byte waits in the input register; its result goes into the result register.
// Reset is synchronous and clears the deframing state and both registers, so
// the block waits for a new transfer. When the receiver holds rsp ready low,
// the result register holds its beat, the input register fills and req ready
// drops; nothing is lost.
// ----------------------------------------------------------------------------
module usb_ethernet_rx_deframer
   import uerx_pkg::*;
(
   input logic       clock,
   input logic       reset,
   uerx_req_if.sink  req_ch,
   uerx_rsp_if.source rsp_ch
);

   req_beat_type req_beat;
   req_beat_type beat;
   rsp_beat_type result;
   rsp_beat_type rsp_beat;
   logic         beat_valid;
   logic         space;
   logic         advance;
   logic         emit;

   assign req_beat.rx_byte           = req_ch.rx_byte;
   assign req_beat.first_of_transfer = req_ch.first_of_transfer;
   assign req_beat.transfer_length   = req_ch.transfer_length;

   // a held beat moves on when the result register can take a result
   assign advance = beat_valid && space;

   uerx_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_beat   (req_beat),
      .advance    (advance),
      .beat_valid (beat_valid),
      .beat       (beat)
   );

   uerx_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .beat    (beat),
      .emit    (emit),
      .result  (result)
   );

   uerx_out_stage u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && emit),
      .load_beat (result),
      .space     (space),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .rsp_beat  (rsp_beat)
   );

   assign rsp_ch.kind         = rsp_beat.kind;
   assign rsp_ch.payload_byte = rsp_beat.payload_byte;
   assign rsp_ch.frame_last   = rsp_beat.frame_last;
   assign rsp_ch.frame_length = rsp_beat.frame_length;

endmodule

FILE: hw/rtl/uerx_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// uerx_checker
// port-level checks of the receive deframer
// ----------------------------------------------------------------------------
module uerx_checker
   import uerx_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [KindWidth-1:0]     rsp_kind,
   input logic [7:0]               rsp_payload_byte,
   input logic                     rsp_frame_last,
   input logic [FrameLenWidth-1:0] rsp_frame_length
);

   // stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_payload_byte) && $stable(rsp_frame_last) &&
      $stable(rsp_frame_length))
      else $error("result beat changed while stalled");

   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // only data beats carry a byte or a last mark
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KindData |-> rsp_payload_byte == 8'd0 &&
      !rsp_frame_last)
      else $error("marker or error beat carries payload");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KindEmpty || rsp_kind == KindTruncated) |->
      rsp_frame_length == '0)
      else $error("empty or truncated beat with nonzero length");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KindData |-> rsp_frame_length != '0)
      else $error("payload byte of a zero-length frame");

endmodule

bind usb_ethernet_rx_deframer uerx_checker u_uerx_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_ch.valid),
   .rsp_ready        (rsp_ch.ready),
   .rsp_kind         (rsp_ch.kind),
   .rsp_payload_byte (rsp_ch.payload_byte),
   .rsp_frame_last   (rsp_ch.frame_last),
   .rsp_frame_length (rsp_ch.frame_length)
);
